// File: hdl/ttsg_pkg.sv
// ----------------------------------------------------------------------------
// ttsg_pkg
// shared widths, register indexes, microcode format and control store
// ----------------------------------------------------------------------------
package ttsg_pkg;

  localparam int DEF_TIME_SLICES      = 64;
  localparam int DEF_MAX_THIN_ENTRIES = 6;

  localparam int TIME_W     = 6;  // time slice fields
  localparam int CNT_W      = 3;  // thin_count and remaining entries
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int T_W        = 7;  // running slice, holds overshoot past the window
  localparam int RUN_W      = 7;  // run counter, holds the open-ended run length
  localparam int PC_W       = 3;

  localparam logic [RUN_W-1:0] RUN_ALL = RUN_W'(64);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THIN_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ENTRY = 3'd1;

  // branch conditions
  localparam logic [2:0] C_NEVER       = 3'd0;
  localparam logic [2:0] C_NO_IN       = 3'd1;
  localparam logic [2:0] C_END         = 3'd2;
  localparam logic [2:0] C_ZERO_STRIDE = 3'd3;
  localparam logic [2:0] C_RUN_DONE    = 3'd4;

  // program steps
  localparam logic [PC_W-1:0] PC_WAIT = 3'd0;
  localparam logic [PC_W-1:0] PC_DISP = 3'd1;
  localparam logic [PC_W-1:0] PC_SEL  = 3'd2;
  localparam logic [PC_W-1:0] PC_RUN  = 3'd3;
  localparam logic [PC_W-1:0] PC_SKIP = 3'd4;
  localparam logic [PC_W-1:0] PC_FIN  = 3'd5;
  localparam logic [PC_W-1:0] PC_ADV  = 3'd6;

  // control word: branch to jmp when cond holds, else do the actions and go to nxt
  typedef struct packed {
    logic [2:0]      cond;
    logic [PC_W-1:0] jmp;
    logic [PC_W-1:0] nxt;
    logic            load_win;
    logic            load_entry;
    logic            skip;
    logic            emit;
    logic            finish;
    logic            adv;
  } cw_t;

  // actions handed to the datapath
  typedef struct packed {
    logic idle;
    logic load_win;
    logic load_entry;
    logic skip;
    logic emit;
    logic finish;
    logic adv;
  } act_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic at_end;
    logic zero_stride;
    logic run_done;
    logic pend_v;
    logic out_busy;
  } stat_t;

  function automatic cw_t ucode(input logic [PC_W-1:0] pc);
    cw_t cw;
    cw = '0;
    case (pc)
      PC_WAIT: begin
        cw.cond = C_NO_IN;       cw.jmp = PC_WAIT; cw.nxt = PC_DISP; cw.load_win = 1'b1;
      end
      PC_DISP: begin
        cw.cond = C_END;         cw.jmp = PC_FIN;  cw.nxt = PC_SEL;  cw.load_entry = 1'b1;
      end
      PC_SEL: begin
        cw.cond = C_ZERO_STRIDE; cw.jmp = PC_SKIP; cw.nxt = PC_RUN;
      end
      PC_RUN: begin
        cw.cond = C_RUN_DONE;    cw.jmp = PC_ADV;  cw.nxt = PC_RUN;  cw.emit = 1'b1;
      end
      PC_SKIP: begin
        cw.cond = C_NEVER;       cw.jmp = PC_DISP; cw.nxt = PC_DISP; cw.skip = 1'b1;
        cw.adv = 1'b1;
      end
      PC_FIN: begin
        cw.cond = C_NEVER;       cw.jmp = PC_WAIT; cw.nxt = PC_WAIT; cw.finish = 1'b1;
      end
      PC_ADV: begin
        cw.cond = C_NEVER;       cw.jmp = PC_DISP; cw.nxt = PC_DISP; cw.adv = 1'b1;
      end
      default: begin
        cw.cond = C_NEVER;       cw.jmp = PC_WAIT; cw.nxt = PC_WAIT;
      end
    endcase
    return cw;
  endfunction

endpackage

// File: hdl/ttsg_sequencer.sv
// ----------------------------------------------------------------------------
// ttsg_sequencer
// step counter, control store and branch logic
// ----------------------------------------------------------------------------
module ttsg_sequencer
  import ttsg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output act_t  act
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  cw_t             cw;
  logic            jump;
  logic            hold;
  logic            fire;

  assign cw = ucode(pc_r);

  always_comb begin
    case (cw.cond)
      C_NEVER:       jump = 1'b0;
      C_NO_IN:       jump = !stat.in_valid;
      C_END:         jump = stat.at_end;
      C_ZERO_STRIDE: jump = stat.zero_stride;
      C_RUN_DONE:    jump = stat.run_done;
      default:       jump = 1'b0;
    endcase
  end

  // wait for the output register when this step has to write it
  assign hold = !jump && stat.out_busy &&
                ((cw.emit && stat.pend_v) || cw.finish);
  assign fire = !jump && !hold;

  always_comb begin
    if (hold) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = cw.jmp;
    end else begin
      pc_nxt = cw.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign act.idle       = (pc_r == PC_WAIT);
  assign act.load_win   = cw.load_win   && fire;
  assign act.load_entry = cw.load_entry && fire;
  assign act.skip       = cw.skip       && fire;
  assign act.emit       = cw.emit       && fire;
  assign act.finish     = cw.finish     && fire;
  assign act.adv        = cw.adv        && fire;

endmodule

// File: hdl/ttsg_datapath.sv
// ----------------------------------------------------------------------------
// ttsg_datapath
// slice counter, thinning entry shift line, pending item and output register
// ----------------------------------------------------------------------------
module ttsg_datapath
  import ttsg_pkg::*;
#(
  parameter int TIME_SLICES      = DEF_TIME_SLICES,
  parameter int MAX_THIN_ENTRIES = DEF_MAX_THIN_ENTRIES,
  localparam int PAIRS           = (MAX_THIN_ENTRIES + 1) / 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  act_t                  act,
  output stat_t                 stat,
  input  logic [CNT_W-1:0]      cfg_n,
  input  logic [TIME_W-1:0]     cfg_str  [PAIRS],
  input  logic [TIME_W-1:0]     cfg_cnt  [PAIRS],
  input  logic                  in_valid,
  input  logic [TIME_W-1:0]     in_first_time,
  input  logic [TIME_W-1:0]     in_last_time,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TIME_W-1:0]     out_fit_time,
  output logic                  out_last_of_run,
  output logic                  out_empty_window
);

  localparam logic [TIME_W-1:0] T_MAX = TIME_W'(TIME_SLICES - 1);
  localparam logic [CNT_W-1:0]  N_MAX = CNT_W'(MAX_THIN_ENTRIES);

  logic [T_W-1:0]    t_r;
  logic [TIME_W-1:0] tf_r;
  logic [CNT_W-1:0]  rem_r;
  logic [TIME_W-1:0] stride_r;
  logic [RUN_W-1:0]  run_r;
  logic              final_r;
  logic              pend_v_r;
  logic [TIME_W-1:0] pend_t_r;
  logic [TIME_W-1:0] wstr_r [PAIRS];
  logic [TIME_W-1:0] wcnt_r [PAIRS];
  logic              out_valid_r;
  logic [TIME_W-1:0] out_time_r;
  logic              out_last_r;
  logic              out_empty_r;

  logic [TIME_W-1:0] first_sat;
  logic [TIME_W-1:0] last_sat;
  logic [CNT_W-1:0]  n_clamp;
  logic              past_end;

  assign first_sat = (in_first_time > T_MAX) ? T_MAX : in_first_time;
  assign last_sat  = (in_last_time  > T_MAX) ? T_MAX : in_last_time;
  assign n_clamp   = (cfg_n > N_MAX) ? N_MAX : cfg_n;
  assign past_end  = (t_r > {1'b0, tf_r});

  assign stat.in_valid    = in_valid;
  assign stat.at_end      = (rem_r == '0) || past_end;
  assign stat.zero_stride = (stride_r == '0);
  assign stat.run_done    = (run_r == '0) || past_end;
  assign stat.pend_v      = pend_v_r;
  assign stat.out_busy    = out_valid_r && out_stall;

  // window and thinning walk
  always_ff @(posedge clk) begin
    if (act.load_win) begin
      t_r  <= {1'b0, first_sat};
      tf_r <= last_sat;
      // no thinning runs as one open-ended entry of stride one
      rem_r <= (cfg_n == '0) ? CNT_W'(1) : n_clamp;
      for (int k = 0; k < PAIRS; k++) begin
        wstr_r[k] <= ((k == 0) && (cfg_n == '0)) ? TIME_W'(1) : cfg_str[k];
        wcnt_r[k] <= cfg_cnt[k];
      end
    end
    if (act.load_entry) begin
      stride_r <= wstr_r[0];
      final_r  <= (rem_r == CNT_W'(1));
      run_r    <= (rem_r == CNT_W'(1)) ? RUN_ALL : {1'b0, wcnt_r[0]};
    end
    if (act.skip) begin
      t_r <= final_r ? (T_W'(tf_r) + T_W'(1)) : (t_r + run_r);
    end
    if (act.emit) begin
      t_r   <= t_r + T_W'(stride_r);
      run_r <= run_r - RUN_W'(1);
    end
    if (act.adv) begin
      rem_r <= (rem_r < CNT_W'(2)) ? '0 : (rem_r - CNT_W'(2));
      for (int k = 0; k < PAIRS - 1; k++) begin
        wstr_r[k] <= wstr_r[k + 1];
        wcnt_r[k] <= wcnt_r[k + 1];
      end
    end
  end

  // pending item: the last flag is only known once the next slice is seen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (act.load_win || act.finish) begin
      pend_v_r <= 1'b0;
    end else if (act.emit) begin
      pend_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (act.emit) begin
      pend_t_r <= t_r[TIME_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((act.emit && pend_v_r) || act.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act.emit && pend_v_r) begin
      out_time_r  <= pend_t_r;
      out_last_r  <= 1'b0;
      out_empty_r <= 1'b0;
    end else if (act.finish) begin
      out_time_r  <= pend_v_r ? pend_t_r : '0;
      out_last_r  <= 1'b1;
      out_empty_r <= !pend_v_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fit_time     = out_time_r;
  assign out_last_of_run  = out_last_r;
  assign out_empty_window = out_empty_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(((act.emit && pend_v_r) || act.finish) && out_valid_r && out_stall))
    else $error("output register written while stalled");

  a_fresh_window: assert property (@(posedge clk) disable iff (!rst_n)
    act.load_win |=> !pend_v_r)
    else $error("pending item survives a new window");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_last_r)
    else $error("empty item without last marker");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    act.load_entry |-> (rem_r <= N_MAX) && (rem_r != '0))
    else $error("entry loaded with no entries left");
`endif

endmodule

// File: hdl/thinned_time_sequence_generator.sv
// ----------------------------------------------------------------------------
// thinned_time_sequence_generator
// emits the thinned time slices of a window, one item per slice
// ----------------------------------------------------------------------------
// usage
//   input channel: in_first_time / in_last_time, taken when in_valid is high
//   and in_stall low; in_stall stays high from acceptance until the final
//   item of the window has been written to the output register
//   output channel: out_fit_time, out_last_of_run, out_empty_window, moved
//   when out_valid is high and out_stall low; the register holds while stalled
//   configuration: cfg_we with cfg_index and cfg_data, write only while idle;
//   index 0 is thin_count, indexes 1 to 6 the stride / count entries
//   timing: the microcode walks one slice per cycle while the output is not
//   stalled, besides the steps that load, select and advance each thinning
//   entry and those for window setup and finish; each slice is held back
//   as the pending item until the next slice is emitted or the window
//   finishes, to learn whether it is the last
//   an empty window, or one where thinning selects nothing, gives one item
//   flagged empty and last
//   reset: synchronous, clears the step counter, the valid flags and the
//   thinning registers (no thinning); in_stall is held high during reset
//   a stalled receiver stops the walk at the next slice that needs the
//   output register
// ----------------------------------------------------------------------------
module thinned_time_sequence_generator
  import ttsg_pkg::*;
#(
  parameter int TIME_SLICES      = DEF_TIME_SLICES,
  parameter int MAX_THIN_ENTRIES = DEF_MAX_THIN_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // window items in
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_W-1:0]     in_first_time,
  input  logic [TIME_W-1:0]     in_last_time,
  // slice items out
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TIME_W-1:0]     out_fit_time,
  output logic                  out_last_of_run,
  output logic                  out_empty_window
);

  localparam int PAIRS = (MAX_THIN_ENTRIES + 1) / 2;

  // thinning registers, kept as stride / count pairs
  logic [CNT_W-1:0]     cfg_n_r;
  logic [TIME_W-1:0]    cfg_str_r [PAIRS];
  logic [TIME_W-1:0]    cfg_cnt_r [PAIRS];
  logic [CFG_IDX_W-1:0] entry_sel;

  act_t  act;
  stat_t stat;

  // entry number within the list, valid for indexes from one up
  assign entry_sel = cfg_index - REG_FIRST_ENTRY;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_n_r <= '0;
      for (int k = 0; k < PAIRS; k++) begin
        cfg_str_r[k] <= '0;
        cfg_cnt_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_THIN_COUNT) begin
        cfg_n_r <= cfg_data[CNT_W-1:0];
      end else begin
        // entries past the configured maximum are never read, so drop them
        for (int k = 0; k < PAIRS; k++) begin
          if ((entry_sel == CFG_IDX_W'(2 * k)) && (2 * k < MAX_THIN_ENTRIES)) begin
            cfg_str_r[k] <= cfg_data[TIME_W-1:0];
          end
          if ((entry_sel == CFG_IDX_W'(2 * k + 1)) && (2 * k + 1 < MAX_THIN_ENTRIES)) begin
            cfg_cnt_r[k] <= cfg_data[TIME_W-1:0];
          end
        end
      end
    end
  end

  ttsg_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .act   (act)
  );

  ttsg_datapath #(
    .TIME_SLICES      (TIME_SLICES),
    .MAX_THIN_ENTRIES (MAX_THIN_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .act              (act),
    .stat             (stat),
    .cfg_n            (cfg_n_r),
    .cfg_str          (cfg_str_r),
    .cfg_cnt          (cfg_cnt_r),
    .in_valid         (in_valid),
    .in_first_time    (in_first_time),
    .in_last_time     (in_last_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fit_time     (out_fit_time),
    .out_last_of_run  (out_last_of_run),
    .out_empty_window (out_empty_window)
  );

  // windows are taken only at the wait step, and never during reset
  assign in_stall = !act.idle || !rst_n;

endmodule
